// ===== sv/mtd_pkg.sv =====
package mtd_pkg;

  // Deadline width and the disarmed marker
  localparam int unsigned DeadlineWidth = 64;
  localparam logic [DeadlineWidth-1:0] U64Max = '1;

  // Saturating event counters; the result item carries their low 32 bits
  localparam int unsigned CountWidth    = 32;
  localparam int unsigned OutCountWidth = 32;
  localparam logic [CountWidth-1:0] CountMax = '1;

  // Packed widths of the stream ports
  localparam int unsigned InDataWidth  = 64;
  localparam int unsigned InUserWidth  = 2;
  localparam int unsigned OutFieldBits = DeadlineWidth + 2 + 2 * OutCountWidth;
  localparam int unsigned OutDataWidth = ((OutFieldBits + 7) / 8) * 8;

  typedef logic [DeadlineWidth-1:0] deadline_t;
  typedef logic [CountWidth-1:0]    count_t;

  // Request kinds carried in tuser
  typedef enum logic [InUserWidth-1:0] {
    ReqSetCallout  = 2'd0,
    ReqSetPreempt  = 2'd1,
    ReqSetWatchdog = 2'd2,
    ReqTimerIrq    = 2'd3
  } req_kind_e;

  // One result item, first field in the highest bits
  typedef struct packed {
    logic [OutDataWidth-OutFieldBits-1:0] pad;
    logic [OutCountWidth-1:0]             skip_count;
    logic [OutCountWidth-1:0]             write_count;
    logic                                 armed_mode;
    logic                                 timer_written;
    deadline_t                            programmed_deadline;
  } result_t;

  // Smallest of three deadlines
  function automatic deadline_t min3(deadline_t a, deadline_t b, deadline_t c);
    deadline_t m;
    m = a;
    if (b < m) m = b;
    if (c < m) m = c;
    return m;
  endfunction

endpackage

// ===== sv/merged_timer_deadline_top.sv =====
// Merged timer deadline.
// Holds the callout, preemption and watchdog deadlines and keeps one hardware
// compare deadline equal to the earliest of them (all ones = disarmed).
// Input stream: s_axis_tuser carries the request kind (set callout, set
// preempt, set watchdog, timer interrupt), s_axis_tdata the new deadline or,
// for an interrupt, the current time. An interrupt disarms every source whose
// deadline is at or before that time.
// Output stream: one result item per input item with the programmed deadline,
// a reprogrammed flag, the armed mode and saturating write and skip counts.
// An accepted item is held in the input register and its result is
// registered in the result register, from which it is offered on m_axis.
// Throughput: one item per cycle while the receiver does not stall; the state
// update happens in the cycle that moves an item from the input register to
// the result register. When the receiver stalls, the result register holds and
// the input register takes one more item, after which s_axis_tready falls.
// Reset: all sources and the hardware deadline are disarmed, mode is
// shutdown, both counters are zero and both registers are empty.
module merged_timer_deadline_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [63:0] value
  input  logic [mtd_pkg::InDataWidth-1:0]  s_axis_tdata,
  // [1:0] req_type
  input  logic [mtd_pkg::InUserWidth-1:0]  s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [63:0] programmed_deadline, [64] timer_written, [65] armed_mode,
  // [97:66] write_count, [129:98] skip_count, [135:130] zero
  output logic [mtd_pkg::OutDataWidth-1:0] m_axis_tdata
);

  // Input register
  logic                   in_valid_q;
  mtd_pkg::req_kind_e     in_kind_q;
  mtd_pkg::deadline_t     in_value_q;

  // Deadline state and counters
  mtd_pkg::deadline_t callout_q, callout_d;
  mtd_pkg::deadline_t preempt_q, preempt_d;
  mtd_pkg::deadline_t watchdog_q, watchdog_d;
  mtd_pkg::deadline_t hw_deadline_q, hw_deadline_d;
  logic               armed_q, armed_d;
  mtd_pkg::count_t    writes_q, writes_d;
  mtd_pkg::count_t    skips_q, skips_d;

  // Result register
  logic               out_valid_q;
  mtd_pkg::result_t   out_q, out_d;

  logic               advance;
  logic               in_load;
  logic               changed;
  mtd_pkg::deadline_t merged;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_load       = s_axis_tvalid && s_axis_tready;

  // Source update for the item in the input register
  always_comb begin
    callout_d  = callout_q;
    preempt_d  = preempt_q;
    watchdog_d = watchdog_q;
    unique case (in_kind_q)
      mtd_pkg::ReqSetCallout:  callout_d  = in_value_q;
      mtd_pkg::ReqSetPreempt:  preempt_d  = in_value_q;
      mtd_pkg::ReqSetWatchdog: watchdog_d = in_value_q;
      mtd_pkg::ReqTimerIrq: begin
        if (callout_q <= in_value_q)  callout_d  = mtd_pkg::U64Max;
        if (preempt_q <= in_value_q)  preempt_d  = mtd_pkg::U64Max;
        if (watchdog_q <= in_value_q) watchdog_d = mtd_pkg::U64Max;
      end
      default: ;
    endcase
  end

  // Merge, compare with programmed deadline, count
  always_comb begin
    merged        = mtd_pkg::min3(callout_d, preempt_d, watchdog_d);
    changed       = (merged != hw_deadline_q);
    armed_d       = (merged != mtd_pkg::U64Max);
    hw_deadline_d = merged;
    writes_d      = writes_q;
    skips_d       = skips_q;
    if (changed) begin
      if (writes_q != mtd_pkg::CountMax) writes_d = writes_q + mtd_pkg::CountWidth'(1);
    end else begin
      if (skips_q != mtd_pkg::CountMax) skips_d = skips_q + mtd_pkg::CountWidth'(1);
    end
    out_d.pad                 = '0;
    out_d.programmed_deadline = merged;
    out_d.timer_written       = changed;
    out_d.armed_mode          = armed_d;
    out_d.write_count         = mtd_pkg::OutCountWidth'(writes_d);
    out_d.skip_count          = mtd_pkg::OutCountWidth'(skips_d);
  end

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      callout_q     <= mtd_pkg::U64Max;
      preempt_q     <= mtd_pkg::U64Max;
      watchdog_q    <= mtd_pkg::U64Max;
      hw_deadline_q <= mtd_pkg::U64Max;
      armed_q       <= 1'b0;
      writes_q      <= '0;
      skips_q       <= '0;
    end else begin
      if (in_load) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q   <= 1'b1;
        callout_q     <= callout_d;
        preempt_q     <= preempt_d;
        watchdog_q    <= watchdog_d;
        hw_deadline_q <= hw_deadline_d;
        armed_q       <= armed_d;
        writes_q      <= writes_d;
        skips_q       <= skips_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_load) begin
      in_kind_q  <= mtd_pkg::req_kind_e'(s_axis_tuser);
      in_value_q <= s_axis_tdata;
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  // Programmed deadline always tracks the earliest source
  a_hw_is_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hw_deadline_q == mtd_pkg::min3(callout_q, preempt_q, watchdog_q))
    else $error("hardware deadline differs from earliest source");

  // Armed mode agrees with the programmed deadline
  a_armed_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    armed_q == (hw_deadline_q != mtd_pkg::U64Max))
    else $error("armed mode inconsistent with deadline");

  // Each processed item bumps exactly one counter unless saturated
  a_one_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (writes_q != $past(writes_q)) != (skips_q != $past(skips_q))
                || $past(writes_q) == mtd_pkg::CountMax
                || $past(skips_q) == mtd_pkg::CountMax)
    else $error("counter update mismatch");

  // State only moves with a processed item
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(hw_deadline_q) && $stable(writes_q) && $stable(skips_q))
    else $error("state changed without an item");

endmodule
